[src/esp_pkg.sv]
// shared constants and types for the encoder servo position control block
package esp_pkg;

    // step range of the position counter
    localparam int STEP_LIMIT = 40;
    localparam int POS_W      = 6;
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(STEP_LIMIT);
    localparam logic [POS_W-1:0] POS_CENTER = POS_W'(STEP_LIMIT / 2);

    // configuration register widths
    localparam int WIN_W   = 10;
    localparam int HOLD_W  = 13;
    localparam int ANGLE_W = 9;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 3;

    // configuration reset values
    localparam logic [WIN_W-1:0]   CLK_WINDOW_RST    = WIN_W'(20);
    localparam logic [WIN_W-1:0]   SWITCH_WINDOW_RST = WIN_W'(50);
    localparam logic [WIN_W-1:0]   SETTLE_TICKS_RST  = WIN_W'(20);
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST    = HOLD_W'(1200);
    localparam logic [ANGLE_W-1:0] SERVO_ANGLE_RST   = ANGLE_W'(180);

    // saturation tops of the tick counters
    localparam logic [WIN_W-1:0]  WIN_TOP  = '1;
    localparam logic [HOLD_W-1:0] HOLD_TOP = '1;

    // position times angle, then divide by the step limit via reciprocal
    localparam int PROD_W    = POS_W + ANGLE_W;
    localparam int DEG_W     = 9;
    localparam int DIV_SHIFT = PROD_W + $clog2(STEP_LIMIT);
    localparam longint DIV_RECIP = ((64'd1 << DIV_SHIFT) + STEP_LIMIT - 1) / STEP_LIMIT;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int SCALED_W  = PROD_W + RECIP_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLK_WINDOW       = 3'd0,
        CFG_SWITCH_WINDOW    = 3'd1,
        CFG_SETTLE_TICKS     = 3'd2,
        CFG_HOLD_TICKS       = 3'd3,
        CFG_FULL_SCALE_ANGLE = 3'd4
    } t_cfg_idx;

endpackage

[src/encoder_servo_position_control.sv]
// encoder servo position control top level
//
// Takes one sample tick of the encoder clock, direction and push-switch levels
// per cycle while o_stall is low and returns one result per tick through three
// registered stages before o_valid: the debounce, settle and hold logic and the
// position update run in the first stage, the position times full-scale angle
// product in the second, and the division by the step limit (a reciprocal
// multiply) in the output register. Up to three ticks are in flight, so input
// transfers continue while a result waits at the output; o_stall rises only
// when all three stages hold a result and i_stall is high. Configuration
// writes take effect at once and are meant for an idle block.
module encoder_servo_position_control (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [esp_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [esp_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input tick channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_clk_level,
    input  logic                          i_dir_level,
    input  logic                          i_switch_level,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [esp_pkg::POS_W-1:0]     o_position,
    output logic [esp_pkg::DEG_W-1:0]     o_servo_degrees,
    output logic                          o_end_signal,
    output logic                          o_fine_mode_out,
    output logic                          o_moved
);
    import esp_pkg::*;

    // configuration registers
    logic [WIN_W-1:0]   r_cfg_clk_window;
    logic [WIN_W-1:0]   r_cfg_switch_window;
    logic [WIN_W-1:0]   r_cfg_settle_ticks;
    logic [HOLD_W-1:0]  r_cfg_hold_ticks;
    logic [ANGLE_W-1:0] r_cfg_full_scale_angle;

    // tick state
    logic               r_prev_clk, r_prev_switch;
    logic [WIN_W-1:0]   r_clk_elapsed, r_switch_elapsed, r_settle_count;
    logic               r_clk_seen, r_switch_seen, r_settle_pending;
    logic [HOLD_W-1:0]  r_hold_count;
    logic               r_hold_armed;
    logic [POS_W-1:0]   r_step_position;
    logic               r_fine_mode, r_end_flag;

    // next tick state
    logic               n_prev_clk, n_prev_switch;
    logic [WIN_W-1:0]   n_clk_elapsed, n_switch_elapsed, n_settle_count;
    logic               n_clk_seen, n_switch_seen, n_settle_pending;
    logic [HOLD_W-1:0]  n_hold_count;
    logic               n_hold_armed;
    logic [POS_W-1:0]   n_step_position;
    logic               n_fine_mode, n_end_flag, n_moved;

    // pipeline stages
    logic               r_s1_valid, r_s2_valid, r_o_valid;
    logic [POS_W-1:0]   r_s1_pos, r_s2_pos, r_o_pos;
    logic               r_s1_end, r_s2_end, r_o_end;
    logic               r_s1_fine, r_s2_fine, r_o_fine;
    logic               r_s1_moved, r_s2_moved, r_o_moved;
    logic [PROD_W-1:0]  r_s2_prod;
    logic [DEG_W-1:0]   r_o_deg;

    logic               w_o_ready, w_s2_ready, w_s1_ready, w_in_xfer;
    logic [SCALED_W-1:0] w_scaled;

    // stage ready chain
    assign w_o_ready  = !r_o_valid || !i_stall;
    assign w_s2_ready = !r_s2_valid || w_o_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_stall    = !w_s1_ready;
    assign w_in_xfer  = i_valid && w_s1_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_clk_window       <= CLK_WINDOW_RST;
            r_cfg_switch_window    <= SWITCH_WINDOW_RST;
            r_cfg_settle_ticks     <= SETTLE_TICKS_RST;
            r_cfg_hold_ticks       <= HOLD_TICKS_RST;
            r_cfg_full_scale_angle <= SERVO_ANGLE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_CLK_WINDOW:       r_cfg_clk_window       <= i_cfg_wdata[WIN_W-1:0];
                CFG_SWITCH_WINDOW:    r_cfg_switch_window    <= i_cfg_wdata[WIN_W-1:0];
                CFG_SETTLE_TICKS:     r_cfg_settle_ticks     <= i_cfg_wdata[WIN_W-1:0];
                CFG_HOLD_TICKS:       r_cfg_hold_ticks       <= i_cfg_wdata[HOLD_W-1:0];
                CFG_FULL_SCALE_ANGLE: r_cfg_full_scale_angle <= i_cfg_wdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // one tick of debounce, settle, step and hold logic
    always_comb begin
        logic [POS_W:0] v_sum;
        logic [POS_W-1:0] v_step;

        n_clk_elapsed    = (r_clk_elapsed < WIN_TOP) ? r_clk_elapsed + 1'b1 : WIN_TOP;
        n_switch_elapsed = (r_switch_elapsed < WIN_TOP) ? r_switch_elapsed + 1'b1 : WIN_TOP;
        n_settle_count   = r_settle_count;
        if (r_settle_pending && r_settle_count < WIN_TOP) begin
            n_settle_count = r_settle_count + 1'b1;
        end
        n_hold_count     = r_hold_count;
        if (r_hold_armed && r_hold_count < HOLD_TOP) begin
            n_hold_count = r_hold_count + 1'b1;
        end
        n_clk_seen       = r_clk_seen;
        n_switch_seen    = r_switch_seen;
        n_settle_pending = r_settle_pending;
        n_hold_armed     = r_hold_armed;
        n_step_position  = r_step_position;
        n_fine_mode      = r_fine_mode;
        n_end_flag       = r_end_flag;
        n_moved          = 1'b0;
        n_prev_clk       = i_clk_level;
        n_prev_switch    = i_switch_level;
        v_step           = r_fine_mode ? POS_W'(1) : POS_W'(2);

        // settle check of a pending press
        if (r_settle_pending && n_settle_count >= r_cfg_settle_ticks) begin
            n_settle_pending = 1'b0;
            if (!i_switch_level) begin
                n_switch_seen    = 1'b1;
                n_switch_elapsed = n_settle_count;
                n_fine_mode      = !r_fine_mode;
                n_hold_armed     = 1'b1;
                n_hold_count     = '0;
            end
        end

        // encoder clock edge, falling edge steps the position
        v_step = n_fine_mode ? POS_W'(1) : POS_W'(2);
        v_sum  = {1'b0, r_step_position} + {1'b0, v_step};
        if (i_clk_level != r_prev_clk &&
            (!r_clk_seen || n_clk_elapsed >= r_cfg_clk_window)) begin
            n_clk_seen    = 1'b1;
            n_clk_elapsed = '0;
            if (!i_clk_level) begin
                if (i_dir_level) begin
                    n_step_position = (r_step_position > v_step) ?
                                      r_step_position - v_step : '0;
                end else begin
                    n_step_position = (v_sum < {1'b0, POS_MAX}) ? v_sum[POS_W-1:0] : POS_MAX;
                end
                n_moved = 1'b1;
            end
        end

        // switch press edge starts a settle check
        if (r_prev_switch && !i_switch_level && !n_settle_pending) begin
            if (!n_switch_seen || n_switch_elapsed >= r_cfg_switch_window) begin
                n_settle_pending = 1'b1;
                n_settle_count   = '0;
            end
        end

        // long press re-centres
        if (n_hold_armed && n_hold_count >= r_cfg_hold_ticks) begin
            n_hold_armed = 1'b0;
            if (!i_switch_level) begin
                n_step_position = POS_CENTER;
                n_moved         = 1'b1;
            end
        end

        if (n_moved) begin
            n_end_flag = (n_step_position == '0) || (n_step_position == POS_MAX);
        end
    end

    // tick state update on input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clk       <= 1'b1;
            r_prev_switch    <= 1'b1;
            r_clk_elapsed    <= '0;
            r_clk_seen       <= 1'b0;
            r_switch_elapsed <= '0;
            r_switch_seen    <= 1'b0;
            r_settle_count   <= '0;
            r_settle_pending <= 1'b0;
            r_hold_count     <= '0;
            r_hold_armed     <= 1'b0;
            r_step_position  <= '0;
            r_fine_mode      <= 1'b0;
            r_end_flag       <= 1'b1;
        end else if (w_in_xfer) begin
            r_prev_clk       <= n_prev_clk;
            r_prev_switch    <= n_prev_switch;
            r_clk_elapsed    <= n_clk_elapsed;
            r_clk_seen       <= n_clk_seen;
            r_switch_elapsed <= n_switch_elapsed;
            r_switch_seen    <= n_switch_seen;
            r_settle_count   <= n_settle_count;
            r_settle_pending <= n_settle_pending;
            r_hold_count     <= n_hold_count;
            r_hold_armed     <= n_hold_armed;
            r_step_position  <= n_step_position;
            r_fine_mode      <= n_fine_mode;
            r_end_flag       <= n_end_flag;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= w_in_xfer;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_o_ready) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // reciprocal multiply for the division by the step limit
    assign w_scaled = SCALED_W'(r_s2_prod) * SCALED_W'(DIV_RECIP);

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_pos   <= n_step_position;
            r_s1_end   <= n_end_flag;
            r_s1_fine  <= n_fine_mode;
            r_s1_moved <= n_moved;
        end
        if (w_s2_ready && r_s1_valid) begin
            r_s2_pos   <= r_s1_pos;
            r_s2_end   <= r_s1_end;
            r_s2_fine  <= r_s1_fine;
            r_s2_moved <= r_s1_moved;
            r_s2_prod  <= PROD_W'(r_s1_pos) * PROD_W'(r_cfg_full_scale_angle);
        end
        if (w_o_ready && r_s2_valid) begin
            r_o_pos   <= r_s2_pos;
            r_o_end   <= r_s2_end;
            r_o_fine  <= r_s2_fine;
            r_o_moved <= r_s2_moved;
            r_o_deg   <= w_scaled[DIV_SHIFT +: DEG_W];
        end
    end

    // result ports
    assign o_valid         = r_o_valid;
    assign o_position      = r_o_pos;
    assign o_servo_degrees = r_o_deg;
    assign o_end_signal    = r_o_end;
    assign o_fine_mode_out = r_o_fine;
    assign o_moved         = r_o_moved;

    // position never leaves the step range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_position <= POS_MAX))
        else $error("position beyond step limit");

    // a move refreshes the end flag from the new position
    a_end_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_moved) |->
            (o_end_signal == ((o_position == '0) || (o_position == POS_MAX))))
        else $error("end flag does not match moved position");

    // servo angle stays within the configured maximum
    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_servo_degrees <= r_cfg_full_scale_angle))
        else $error("servo angle above maximum");

endmodule

[test/encoder_servo_position_control_tb.sv]
// testbench for the encoder servo position control block: random and directed ticks
module encoder_servo_position_control_tb;
    import esp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 12;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int WIN_MAX      = 1023;
    localparam int HOLD_MAX     = 8191;
    localparam int PHASES       = 9;
    localparam int PHASE_TICKS  = 56;

    // one sample tick of the three pins
    typedef struct packed {
        logic clk_lvl;
        logic dir_lvl;
        logic sw_lvl;
    } t_pin_tick;

    // one expected result of a tick
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [DEG_W-1:0] degrees;
        logic             end_sig;
        logic             fine;
        logic             moved;
    } t_tick_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_clk_level = 1'b1;
    logic                 i_dir_level = 1'b0;
    logic                 i_switch_level = 1'b1;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [POS_W-1:0]     o_position;
    logic [DEG_W-1:0]     o_servo_degrees;
    logic                 o_end_signal;
    logic                 o_fine_mode_out;
    logic                 o_moved;

    t_pin_tick    pending_ticks[$];
    t_tick_result expected_results[$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    logic         tick_sent = 1'b0;
    int           send_idle_pct = 15;
    int           recv_idle_pct = 76;

    // position counter model state
    logic enc_prev_clk, sw_prev;
    int   clk_since, sw_since, settle_cnt, hold_cnt, step_pos;
    logic clk_any, sw_any, settle_busy, hold_on, fine_on, at_end;
    int   win_clk, win_sw, settle_len, hold_len, angle_max;

    // stimulus generator state
    logic gen_clk = 1'b1, gen_dir = 1'b0, gen_sw = 1'b1;
    int   gen_clk_left = 0, gen_dir_left = 0, gen_sw_left = 0;
    int   gen_clk_span = 4, gen_press_span = 8, gen_release_span = 8;

    encoder_servo_position_control dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_clk_level    (i_clk_level),
        .i_dir_level    (i_dir_level),
        .i_switch_level (i_switch_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_position     (o_position),
        .o_servo_degrees(o_servo_degrees),
        .o_end_signal   (o_end_signal),
        .o_fine_mode_out(o_fine_mode_out),
        .o_moved        (o_moved)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic reset_position_model();
        enc_prev_clk = 1'b1;
        sw_prev      = 1'b1;
        clk_since    = 0;
        clk_any      = 1'b0;
        sw_since     = 0;
        sw_any       = 1'b0;
        settle_cnt   = 0;
        settle_busy  = 1'b0;
        hold_cnt     = 0;
        hold_on      = 1'b0;
        step_pos     = 0;
        fine_on      = 1'b0;
        at_end       = 1'b1;
        win_clk      = CLK_WINDOW_RST;
        win_sw       = SWITCH_WINDOW_RST;
        settle_len   = SETTLE_TICKS_RST;
        hold_len     = HOLD_TICKS_RST;
        angle_max    = SERVO_ANGLE_RST;
    endtask

    // advance the position model by one tick and queue the result it gives
    task automatic predict_position(input logic c, input logic d, input logic s);
        int           step;
        logic         mv;
        t_tick_result r;
        mv = 1'b0;
        if (clk_since < WIN_MAX) clk_since++;
        if (sw_since < WIN_MAX) sw_since++;
        if (settle_busy && settle_cnt < WIN_MAX) settle_cnt++;
        if (hold_on && hold_cnt < HOLD_MAX) hold_cnt++;

        // settle recheck of a press
        if (settle_busy && settle_cnt >= settle_len) begin
            settle_busy = 1'b0;
            if (!s) begin
                sw_any   = 1'b1;
                sw_since = settle_cnt;
                fine_on  = !fine_on;
                hold_on  = 1'b1;
                hold_cnt = 0;
            end
        end

        // encoder clock edge
        if (c != enc_prev_clk && (!clk_any || clk_since >= win_clk)) begin
            clk_any   = 1'b1;
            clk_since = 0;
            if (!c) begin
                step = fine_on ? 1 : 2;
                if (d)
                    step_pos = (step_pos > step) ? step_pos - step : 0;
                else
                    step_pos = (step_pos + step < STEP_LIMIT) ? step_pos + step : STEP_LIMIT;
                mv = 1'b1;
            end
        end
        enc_prev_clk = c;

        // press edge, ignored while a recheck is pending
        if (sw_prev && !s && !settle_busy && (!sw_any || sw_since >= win_sw)) begin
            settle_busy = 1'b1;
            settle_cnt  = 0;
        end
        sw_prev = s;

        // long press re-centres
        if (hold_on && hold_cnt >= hold_len) begin
            hold_on = 1'b0;
            if (!s) begin
                step_pos = STEP_LIMIT / 2;
                mv       = 1'b1;
            end
        end

        if (mv) at_end = (step_pos == 0 || step_pos == STEP_LIMIT);

        r.position = POS_W'(step_pos);
        r.degrees  = DEG_W'((step_pos * angle_max) / STEP_LIMIT);
        r.end_sig  = at_end;
        r.fine     = fine_on;
        r.moved    = mv;
        expected_results.push_back(r);
    endtask

    // monitor: model update, result check and watchdog
    always @(posedge i_clk) begin : monitor
        t_tick_result want;
        logic         out_taken;
        if (!i_rst_n) begin
            reset_position_model();
            tick_sent    = 1'b0;
            quiet_cycles = 0;
        end else begin
            tick_sent = i_valid && !o_stall;
            out_taken = o_valid && !i_stall;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_CLK_WINDOW:       win_clk    = i_cfg_wdata[WIN_W-1:0];
                    CFG_SWITCH_WINDOW:    win_sw     = i_cfg_wdata[WIN_W-1:0];
                    CFG_SETTLE_TICKS:     settle_len = i_cfg_wdata[WIN_W-1:0];
                    CFG_HOLD_TICKS:       hold_len   = i_cfg_wdata[HOLD_W-1:0];
                    CFG_FULL_SCALE_ANGLE: angle_max  = i_cfg_wdata[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (tick_sent) predict_position(i_clk_level, i_dir_level, i_switch_level);
            if (out_taken) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with no tick waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (o_position !== want.position)
                        report_mismatch($sformatf("position got %0d want %0d",
                                                  o_position, want.position));
                    if (o_servo_degrees !== want.degrees)
                        report_mismatch($sformatf("servo_degrees got %0d want %0d",
                                                  o_servo_degrees, want.degrees));
                    if (o_end_signal !== want.end_sig)
                        report_mismatch($sformatf("end_signal got %0b want %0b",
                                                  o_end_signal, want.end_sig));
                    if (o_fine_mode_out !== want.fine)
                        report_mismatch($sformatf("fine_mode_out got %0b want %0b",
                                                  o_fine_mode_out, want.fine));
                    if (o_moved !== want.moved)
                        report_mismatch($sformatf("moved got %0b want %0b",
                                                  o_moved, want.moved));
                end
            end
            if (tick_sent || out_taken) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // tick driver: holds a payload until its transfer, then may idle
    always @(negedge i_clk) begin : driver
        t_pin_tick t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tick_sent) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t = pending_ticks.pop_front();
                i_valid        <= 1'b1;
                i_clk_level    <= t.clk_lvl;
                i_dir_level    <= t.dir_lvl;
                i_switch_level <= t.sw_lvl;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic push_tick(input logic c, input logic d, input logic s);
        t_pin_tick t;
        t.clk_lvl = c;
        t.dir_lvl = d;
        t.sw_lvl  = s;
        pending_ticks.push_back(t);
    endtask

    function automatic int pick_run(input int span);
        return ($urandom_range(3) == 0) ? 0 : $urandom_range(span);
    endfunction

    // encoder-like level runs with bounces, plus some fully random ticks
    task automatic queue_ticks(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                push_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end else begin
                if (gen_clk_left == 0) begin
                    gen_clk      = !gen_clk;
                    gen_clk_left = pick_run(gen_clk_span);
                end else begin
                    gen_clk_left--;
                end
                if (gen_dir_left == 0) begin
                    gen_dir      = !gen_dir;
                    gen_dir_left = $urandom_range(4, 50);
                end else begin
                    gen_dir_left--;
                end
                if (gen_sw_left == 0) begin
                    gen_sw      = !gen_sw;
                    gen_sw_left = pick_run(gen_sw ? gen_release_span : gen_press_span);
                end else begin
                    gen_sw_left--;
                end
                push_tick(gen_clk, gen_dir, gen_sw);
            end
        end
    endtask

    // write all five registers on consecutive cycles
    task automatic load_config(input int cw, input int sw, input int st, input int ht,
                               input int ang);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_CLK_WINDOW;
        i_cfg_wdata <= CFG_W'(cw);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_SWITCH_WINDOW;
        i_cfg_wdata <= CFG_W'(sw);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_SETTLE_TICKS;
        i_cfg_wdata <= CFG_W'(st);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_HOLD_TICKS;
        i_cfg_wdata <= CFG_W'(ht);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_FULL_SCALE_ANGLE;
        i_cfg_wdata <= CFG_W'(ang);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_clk_span     = (cw + 2 < 40) ? cw + 2 : 40;
        gen_press_span   = (st + ht + 4 < 80) ? st + ht + 4 : 80;
        gen_release_span = (sw + 4 < 60) ? sw + 4 : 60;
    endtask

    // wait until every tick is sent and every result is back, then let the pipe settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        int ph, k;
        int cw, sw, st, ht, ang;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: first edge is always taken, quick bounces are not
        push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0);
        wait_drained();

        // zero windows and times: every edge taken, settle and hold fire at once
        load_config(0, 0, 0, 0, 360);
        push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0);
        wait_drained();

        // short windows: bounces, press during settle, hold expiry with a step
        load_config(2, 3, 2, 4, 7);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        for (k = 0; k < 8; k++) push_tick(k[0], 1'b0, 1'b0);
        wait_drained();

        // random phases over several register settings
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 15;
            end
            if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cw  = $urandom_range(0, 6);
            sw  = $urandom_range(0, 12);
            st  = $urandom_range(0, 8);
            ht  = $urandom_range(0, 40);
            ang = ($urandom_range(3) == 0) ? 511 : $urandom_range(1, 360);
            if (ph == 0) begin
                cw  = WIN_MAX;
                sw  = WIN_MAX;
                st  = WIN_MAX;
                ht  = HOLD_MAX;
                ang = 511;
            end else if (ph == 5) begin
                cw  = 1;
                sw  = 1;
                st  = 1;
                ht  = 1;
                ang = 1;
            end else if (ph == 7) begin
                ang = 0;
            end
            load_config(cw, sw, st, ht, ang);
            queue_ticks(PHASE_TICKS);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
